// ===== hdl/bhgf_pkg.sv =====
// Shared types and constants for the block header gas fee checker.
`timescale 1ns / 1ps
package bhgf_pkg;

    localparam int NUM_W   = 63;
    localparam int WORD_W  = 64;
    localparam int PROD_W  = 128;
    localparam int DIV_W   = 62;
    localparam int N_CELLS = PROD_W;

    localparam logic [62:0] LONDON_RESET = 63'd12965000;
    localparam logic [63:0] INITIAL_FEE  = 64'd1000000000;
    localparam logic [7:0]  EXTRA_MAX    = 8'd32;
    localparam logic [63:0] MIN_LIMIT    = 64'd5000;

    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_NUMBER   = 4'd1,
        ERR_EXTRA    = 4'd2,
        ERR_TIME     = 4'd3,
        ERR_LIMITMAX = 4'd4,
        ERR_USED     = 4'd5,
        ERR_RATIO    = 4'd6,
        ERR_STEP     = 4'd7,
        ERR_MINIMUM  = 4'd8,
        ERR_FEEMISS  = 4'd9,
        ERR_FEEMIS   = 4'd10
    } err_t;

    // per-item data that rides along the divider chain
    typedef struct packed {
        logic              p_london;
        logic              c_london;
        logic              up;
        logic              eq;
        logic              tzero;
        logic [WORD_W-1:0] fee;
        logic [WORD_W-1:0] c_fee;
        err_t              err;
    } side_t;

endpackage

// ===== hdl/bhgf_mul.sv =====
// Two-stage 64x64 multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
module bhgf_mul
    import bhgf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [WORD_W-1:0]   in_a,
    input  logic [WORD_W-1:0]   in_b,
    input  side_t               in_side,
    input  logic [DIV_W-1:0]    in_d,
    output logic                out_valid,
    output logic [PROD_W-1:0]   out_prod,
    output side_t               out_side,
    output logic [DIV_W-1:0]    out_d
);

    logic              v1_reg;
    logic [63:0]       ll_reg, lh_reg, hl_reg, hh_reg;
    side_t             side1_reg;
    logic [DIV_W-1:0]  d1_reg;
    logic              v2_reg;
    logic [PROD_W-1:0] prod_reg;
    side_t             side2_reg;
    logic [DIV_W-1:0]  d2_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb begin
        prod_next = {64'd0, ll_reg} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
                  + {hh_reg, 64'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            ll_reg    <= in_a[31:0]  * in_b[31:0];
            lh_reg    <= in_a[31:0]  * in_b[63:32];
            hl_reg    <= in_a[63:32] * in_b[31:0];
            hh_reg    <= in_a[63:32] * in_b[63:32];
            side1_reg <= in_side;
            d1_reg    <= in_d;
            prod_reg  <= prod_next;
            side2_reg <= side1_reg;
            d2_reg    <= d1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_prod  = prod_reg;
    assign out_side  = side2_reg;
    assign out_d     = d2_reg;

endmodule

// ===== hdl/bhgf_cell.sv =====
// One restoring-division cell: one quotient bit per cell, passed to the next.
`timescale 1ns / 1ps
module bhgf_cell
    import bhgf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [DIV_W-1:0]    in_rem,
    input  logic [PROD_W-1:0]   in_nq,
    input  logic [DIV_W-1:0]    in_d,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [DIV_W-1:0]    out_rem,
    output logic [PROD_W-1:0]   out_nq,
    output logic [DIV_W-1:0]    out_d,
    output side_t               out_side
);

    logic              valid_reg;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] nq_reg, nq_next;
    logic [DIV_W-1:0]  d_reg;
    side_t             side_reg;
    logic [DIV_W:0]    sh;
    logic              ge;

    always_comb begin
        sh       = {in_rem, in_nq[PROD_W-1]};
        ge       = sh >= {1'b0, in_d};
        rem_next = ge ? DIV_W'(sh - {1'b0, in_d}) : sh[DIV_W-1:0];
        nq_next  = {in_nq[PROD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            d_reg    <= in_d;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_d     = d_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/block_header_gas_fee_check_core.sv =====
// Top level of the parent/child block header and base fee checker.
// Usage:
//   s_ channel: one transfer carries a parent/child header pair; the fee
//   presence flags (bit0 parent, bit1 child) travel on s_tuser.
//   m_ channel: one transfer per pair with header_ok, error_code,
//   expected_base_fee and london_rules.
//   cfg_we/cfg_wdata write london_height; write only while the block is idle.
// Pipeline:
//   One check stage, two multiplier stages, a chain of 128 division cells
//   (one quotient bit each) and the output register. Throughput is one
//   pair per cycle unless m_tready stalls it; the divider chain sets the latency.
// Flow control:
//   The whole pipeline advances whenever the output register is empty or
//   being taken, so s_tready follows m_tready while a result is held.
//   A stalled result holds steady and the pipeline freezes behind it.
// Reset:
//   aresetn clears all valid flags and sets london_height to 12965000.
`timescale 1ns / 1ps
module block_header_gas_fee_check_core
    import bhgf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [62:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // parent_number, parent_time, parent_gas_limit, parent_gas_used,
    // parent_base_fee, child_number, child_time, child_gas_limit,
    // child_gas_used, child_base_fee, child_extra_length, zero pad
    input  logic [647:0]  s_tdata,
    // base_fee_present
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // header_ok, error_code, expected_base_fee, london_rules, zero pad
    output logic [71:0]   m_tdata
);

    logic [62:0] london_reg;
    logic        en;

    logic [62:0] p_num, p_lim, p_used, c_num;
    logic [63:0] p_time, p_fee, c_time, c_lim, c_used, c_fee;
    logic [7:0]  c_extra;
    logic        p_london, c_london;
    logic [61:0] target;
    logic [62:0] delta;
    logic [63:0] step_lim, diff, upper, lower;
    err_t        err_a;
    side_t       side_a;

    logic              va_reg;
    side_t             sidea_reg;
    logic [63:0]       fee_a_reg;
    logic [63:0]       delta_a_reg;
    logic [DIV_W-1:0]  d_a_reg;

    logic              mul_valid;
    logic [PROD_W-1:0] mul_prod;
    side_t             mul_side;
    logic [DIV_W-1:0]  mul_d;

    logic              c_valid [N_CELLS+1];
    logic [DIV_W-1:0]  c_rem   [N_CELLS+1];
    logic [PROD_W-1:0] c_nq    [N_CELLS+1];
    logic [DIV_W-1:0]  c_d     [N_CELLS+1];
    side_t             c_side  [N_CELLS+1];

    side_t       fs;
    logic [63:0] dl;
    logic        dh;
    logic [63:0] exp_fee;
    err_t        err_f;

    logic        out_valid_reg;
    logic        ok_reg, ok_next;
    err_t        code_reg;
    logic [63:0] exp_reg;
    logic        lr_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            london_reg <= LONDON_RESET;
        end else if (cfg_we) begin
            london_reg <= cfg_wdata;
        end
    end

    // header checks
    always_comb begin
        p_num    = s_tdata[62:0];
        p_time   = s_tdata[126:63];
        p_lim    = s_tdata[189:127];
        p_used   = s_tdata[252:190];
        p_fee    = s_tdata[316:253];
        c_num    = s_tdata[379:317];
        c_time   = s_tdata[443:380];
        c_lim    = s_tdata[507:444];
        c_used   = s_tdata[571:508];
        c_fee    = s_tdata[635:572];
        c_extra  = s_tdata[643:636];
        p_london = s_tuser[0] || (p_num >= london_reg);
        c_london = s_tuser[1] || (c_num >= london_reg);
        target   = p_lim[62:1];
        delta    = (p_used > {1'b0, target}) ? p_used - {1'b0, target}
                                             : {1'b0, target} - p_used;
        step_lim = (c_london && !p_london) ? {p_lim, 1'b0} : {1'b0, p_lim};
        diff     = (step_lim >= c_lim) ? step_lim - c_lim : c_lim - step_lim;
        upper    = {1'b0, p_lim} + {11'd0, p_lim[62:10]};
        lower    = {1'b0, p_lim} - ({11'd0, p_lim[62:10]} + {63'd0, |p_lim[9:0]});
        priority if ({1'b0, c_num} != {1'b0, p_num} + 64'd1) err_a = ERR_NUMBER;
        else if (c_extra > EXTRA_MAX)                    err_a = ERR_EXTRA;
        else if (c_time <= p_time)                       err_a = ERR_TIME;
        else if (c_lim[63])                              err_a = ERR_LIMITMAX;
        else if (c_used > c_lim)                         err_a = ERR_USED;
        else if (c_lim > upper || c_lim <= lower)        err_a = ERR_RATIO;
        else if (diff >= {10'd0, step_lim[63:10]})       err_a = ERR_STEP;
        else if (c_lim < MIN_LIMIT)                      err_a = ERR_MINIMUM;
        else if (c_london && !s_tuser[1])                err_a = ERR_FEEMISS;
        else                                             err_a = ERR_OK;
        side_a.p_london = p_london;
        side_a.c_london = c_london;
        side_a.up       = p_used > {1'b0, target};
        side_a.eq       = p_used == {1'b0, target};
        side_a.tzero    = target == '0;
        side_a.fee      = p_fee;
        side_a.c_fee    = c_fee;
        side_a.err      = err_a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
        end
        if (en) begin
            sidea_reg   <= side_a;
            fee_a_reg   <= p_fee;
            delta_a_reg <= {1'b0, delta};
            d_a_reg     <= target;
        end
    end

    bhgf_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_reg),
        .in_a      (fee_a_reg),
        .in_b      (delta_a_reg),
        .in_side   (sidea_reg),
        .in_d      (d_a_reg),
        .out_valid (mul_valid),
        .out_prod  (mul_prod),
        .out_side  (mul_side),
        .out_d     (mul_d)
    );

    assign c_valid[0] = mul_valid;
    assign c_rem[0]   = '0;
    assign c_nq[0]    = mul_prod;
    assign c_d[0]     = mul_d;
    assign c_side[0]  = mul_side;

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        bhgf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (c_valid[i]),
            .in_rem    (c_rem[i]),
            .in_nq     (c_nq[i]),
            .in_d      (c_d[i]),
            .in_side   (c_side[i]),
            .out_valid (c_valid[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_nq    (c_nq[i+1]),
            .out_d     (c_d[i+1]),
            .out_side  (c_side[i+1])
        );
    end

    // fee update and final fee comparison
    always_comb begin
        fs = c_side[N_CELLS];
        dh = |c_nq[N_CELLS][127:67];
        dl = c_nq[N_CELLS][66:3];
        if (!fs.p_london) begin
            exp_fee = INITIAL_FEE;
        end else if (fs.eq) begin
            exp_fee = fs.fee;
        end else if (fs.tzero) begin
            exp_fee = '1;
        end else if (fs.up) begin
            if (!dh && dl == '0) dl = 64'd1;
            exp_fee = (dh || dl > ~fs.fee) ? '1 : fs.fee + dl;
        end else begin
            exp_fee = (dh || dl >= fs.fee) ? '0 : fs.fee - dl;
        end
        err_f = fs.err;
        if (fs.err == ERR_OK && fs.c_london && fs.c_fee != exp_fee) err_f = ERR_FEEMIS;
        ok_next = err_f == ERR_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= c_valid[N_CELLS];
        end
        if (en) begin
            ok_reg   <= ok_next;
            code_reg <= err_f;
            exp_reg  <= exp_fee;
            lr_reg   <= fs.c_london;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, lr_reg, exp_reg, code_reg, ok_reg};

`ifndef SYNTH
    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == ERR_OK)))
        else $error("header_ok disagrees with error_code");
    a_fee_err_needs_london: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[69]) |-> (m_tdata[4:1] != ERR_FEEMISS &&
                                        m_tdata[4:1] != ERR_FEEMIS))
        else $error("fee error without london rules");
    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result present right after reset");
`endif

endmodule

// ===== test/tb_block_header_gas_fee_check_core.sv =====
// Self-checking testbench for the block header gas fee checker core.
`timescale 1ns / 1ps
module tb_block_header_gas_fee_check_core;
    import bhgf_pkg::*;

    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  c_extra;
        logic [63:0] c_fee;
        logic [63:0] c_used;
        logic [63:0] c_lim;
        logic [63:0] c_time;
        logic [62:0] c_num;
        logic [63:0] p_fee;
        logic [62:0] p_used;
        logic [62:0] p_lim;
        logic [63:0] p_time;
        logic [62:0] p_num;
    } hdr_pair_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic        london;
        logic [63:0] fee;
        err_t        err;
        logic        ok;
    } verdict_t;

    typedef struct {
        hdr_pair_t hp;
        logic [1:0] pres;
        bit typed;
        verdict_t v;
    } vec_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [62:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [647:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    logic [62:0]  london_ht = LONDON_RESET;
    verdict_t     verdict_q[$];
    vec_t         vecs[$];
    int           n_fail = 0;
    int           n_mismatch = 0;
    int           n_recv = 0;
    int           idle_cycles = 0;

    block_header_gas_fee_check_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] base_fee_next(bit p_lon, logic [62:0] lim,
                                                  logic [62:0] used, logic [63:0] fee);
        logic [63:0]  tgt;
        logic [127:0] q;
        if (!p_lon)
            return INITIAL_FEE;
        tgt = {1'b0, lim} >> 1;
        if ({1'b0, used} == tgt)
            return fee;
        if ({1'b0, used} > tgt) begin
            if (tgt == 0)
                return '1;
            q = ({64'd0, fee} * {64'd0, {1'b0, used} - tgt}) / {64'd0, tgt};
            q = q >> 3;
            if (q == 0)
                q = 1;
            if (q[127:64] != 0 || q[63:0] > ~fee)
                return '1;
            return fee + q[63:0];
        end
        q = ({64'd0, fee} * {64'd0, tgt - {1'b0, used}}) / {64'd0, tgt};
        q = q >> 3;
        if (q[127:64] != 0 || q[63:0] >= fee)
            return '0;
        return fee - q[63:0];
    endfunction

    function automatic verdict_t header_verdict(hdr_pair_t h, logic [1:0] pres);
        verdict_t    v;
        bit          p_lon, c_lon;
        logic [63:0] plim, step, diff;
        p_lon = pres[0] || h.p_num >= london_ht;
        c_lon = pres[1] || h.c_num >= london_ht;
        plim = {1'b0, h.p_lim};
        step = (c_lon && !p_lon) ? plim << 1 : plim;
        diff = (step >= h.c_lim) ? step - h.c_lim : h.c_lim - step;
        v = '0;
        v.fee = base_fee_next(p_lon, h.p_lim, h.p_used, h.p_fee);
        v.london = c_lon;
        if ({1'b0, h.c_num} != {1'b0, h.p_num} + 64'd1)
            v.err = ERR_NUMBER;
        else if (h.c_extra > EXTRA_MAX)
            v.err = ERR_EXTRA;
        else if (h.c_time <= h.p_time)
            v.err = ERR_TIME;
        else if (h.c_lim[63])
            v.err = ERR_LIMITMAX;
        else if (h.c_used > h.c_lim)
            v.err = ERR_USED;
        else if (h.c_lim > plim + plim / 1024 || h.c_lim <= plim - (plim + 1023) / 1024)
            v.err = ERR_RATIO;
        else if (diff >= step / 1024)
            v.err = ERR_STEP;
        else if (h.c_lim < MIN_LIMIT)
            v.err = ERR_MINIMUM;
        else if (c_lon && !pres[1])
            v.err = ERR_FEEMISS;
        else if (c_lon && h.c_fee != v.fee)
            v.err = ERR_FEEMIS;
        else
            v.err = ERR_OK;
        v.ok = (v.err == ERR_OK);
        return v;
    endfunction

    function automatic hdr_pair_t pair(logic [62:0] pn, logic [63:0] pt, logic [62:0] pl,
                                       logic [62:0] pu, logic [63:0] pf, logic [62:0] cn,
                                       logic [63:0] ct, logic [63:0] cl, logic [63:0] cu,
                                       logic [63:0] cf, logic [7:0] ex);
        hdr_pair_t h;
        h = '0;
        h.p_num = pn; h.p_time = pt; h.p_lim = pl; h.p_used = pu; h.p_fee = pf;
        h.c_num = cn; h.c_time = ct; h.c_lim = cl; h.c_used = cu; h.c_fee = cf;
        h.c_extra = ex;
        return h;
    endfunction

    function automatic void add_vec(hdr_pair_t h, logic [1:0] pres, bit typed,
                                    err_t e, logic [63:0] fee, logic lr);
        vec_t r;
        r.hp = h; r.pres = pres; r.typed = typed;
        r.v = '0; r.v.err = e; r.v.ok = (e == ERR_OK); r.v.fee = fee; r.v.london = lr;
        vecs.push_back(r);
    endfunction

    // mostly well-formed pairs with random content, some broken, some raw noise
    task automatic random_pair(output hdr_pair_t h, output logic [1:0] pres);
        int          kind;
        logic [63:0] r, plim;
        kind = $urandom_range(0, 99);
        h = 648'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        h.pad = '0;
        pres = 2'($urandom_range(0, 3));
        if (kind < 12)
            return;
        if ($urandom_range(0, 2) == 0)
            h.p_num = london_ht + 63'($urandom_range(0, 4)) - 63'd2;
        else
            h.p_num = 63'(rnd64() >> $urandom_range(1, 63));
        h.c_num = h.p_num + 63'd1;
        h.c_extra = 8'($urandom_range(0, 32));
        h.c_time = h.p_time + 64'($urandom_range(1, 30));
        h.p_lim = 63'd3000 + 63'(rnd64() >> $urandom_range(2, 52));
        plim = {1'b0, h.p_lim};
        r = plim / 1024;
        h.c_lim = (r > 1) ? plim - (r - 1) + rnd64() % (2 * r - 1) : plim;
        if ($urandom_range(0, 4) == 0)
            h.p_used = h.p_lim >> 1;
        else
            h.p_used = 63'(rnd64() % (plim + 1));
        h.p_fee = rnd64() >> $urandom_range(0, 63);
        h.c_used = rnd64() % (h.c_lim + 1);
        if ($urandom_range(0, 4) != 0)
            h.c_fee = base_fee_next(pres[0] || h.p_num >= london_ht, h.p_lim, h.p_used,
                                    h.p_fee);
        if (kind < 27) begin
            case ($urandom_range(0, 6))
                0: h.c_num = h.c_num + 63'($urandom_range(1, 3));
                1: h.c_extra = 8'($urandom_range(33, 255));
                2: h.c_time = h.p_time - 64'($urandom_range(0, 2));
                3: h.c_lim = rnd64() | 64'h8000_0000_0000_0000;
                4: h.c_used = h.c_lim + 64'($urandom_range(1, 9));
                5: h.c_lim = plim + plim / 1024 + 64'($urandom_range(0, 2));
                default: h.c_lim = plim * 2;
            endcase
        end
    endtask

    task automatic send_pair(hdr_pair_t h, logic [1:0] pres, bit typed, verdict_t tv,
                             int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= h;
        s_tuser <= pres;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        verdict_q.push_back(typed ? tv : header_verdict(h, pres));
    endtask

    task automatic write_london(logic [62:0] v);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (140) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        london_ht = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        hdr_pair_t  h;
        logic [1:0] pres;
        bit         burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                burst = ($urandom_range(0, 2) == 0);
            random_pair(h, pres);
            send_pair(h, pres, 0, '0, burst ? 0 : $urandom_range(0, 15));
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int       stall;
        bit       held;
        verdict_t got, want;
        held = 0;
        wait (aresetn);
        forever begin
            stall = $urandom_range(0, 15);
            if (n_recv == 300 && !held) begin
                held = 1;
                stall = 600;
            end
            if ((n_recv / 50) % 3 == 2)
                stall = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            got = m_tdata;
            @(posedge aclk);
            n_recv++;
            if (verdict_q.size() == 0) begin
                n_fail++;
                $display("unexpected result transfer: %h", got);
            end else begin
                want = verdict_q.pop_front();
                if (got.ok !== want.ok || got.err !== want.err || got.fee !== want.fee ||
                    got.london !== want.london) begin
                    n_fail++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch #%0d: exp ok=%0d err=%0d fee=%h lr=%0d, got ok=%0d err=%0d fee=%h lr=%0d",
                                 n_recv, want.ok, want.err, want.fee, want.london,
                                 got.ok, got.err, got.fee, got.london);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 20000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        hdr_pair_t b, h;
        b = pair(63'd100, 64'd1000, 63'd30000000, 63'd15000000, 64'd7, 63'd101, 64'd1012,
                 64'd30000000, 64'd0, 64'd0, 8'd0);
        add_vec(b, 2'd0, 1, ERR_OK, INITIAL_FEE, 1'b0);
        h = b; h.c_num = 63'd103;               add_vec(h, 2'd0, 1, ERR_NUMBER, INITIAL_FEE, 1'b0);
        h = b; h.c_extra = 8'd33;               add_vec(h, 2'd0, 1, ERR_EXTRA, INITIAL_FEE, 1'b0);
        h = b; h.c_extra = 8'd32;               add_vec(h, 2'd0, 1, ERR_OK, INITIAL_FEE, 1'b0);
        h = b; h.c_time = 64'd1000;             add_vec(h, 2'd0, 1, ERR_TIME, INITIAL_FEE, 1'b0);
        h = b; h.c_lim = '1;                    add_vec(h, 2'd0, 1, ERR_LIMITMAX, INITIAL_FEE, 1'b0);
        h = b; h.c_used = 64'd30000001;         add_vec(h, 2'd0, 1, ERR_USED, INITIAL_FEE, 1'b0);
        h = b; h.c_lim = 64'd40000000;          add_vec(h, 2'd0, 1, ERR_RATIO, INITIAL_FEE, 1'b0);
        h = b; h.c_lim = 64'd30029296;          add_vec(h, 2'd0, 1, ERR_STEP, INITIAL_FEE, 1'b0);
        h = b; h.p_lim = 63'd4000; h.c_lim = 64'd4000;
        add_vec(h, 2'd0, 1, ERR_MINIMUM, INITIAL_FEE, 1'b0);
        h = b; h.p_num = 63'd12965000; h.c_num = 63'd12965001;
        add_vec(h, 2'd1, 1, ERR_FEEMISS, 64'd7, 1'b1);
        h = b; h.c_fee = 64'd8;                 add_vec(h, 2'd3, 1, ERR_FEEMIS, 64'd7, 1'b1);
        h = b; h.c_fee = 64'd7;                 add_vec(h, 2'd3, 1, ERR_OK, 64'd7, 1'b1);
        h = b; h.p_lim = 63'd1; h.p_used = 63'd5;           add_vec(h, 2'd1, 0, ERR_OK, 0, 0);
        h = b; h.p_fee = '1; h.p_used = 63'd30000000;       add_vec(h, 2'd3, 0, ERR_OK, 0, 0);
        h = b; h.p_fee = 64'd1000; h.p_used = 63'd0;        add_vec(h, 2'd3, 0, ERR_OK, 0, 0);
        h = b; h.p_fee = 64'd0; h.p_used = 63'd0;           add_vec(h, 2'd1, 0, ERR_OK, 0, 0);
        h = b; h.p_fee = 64'd5; h.p_used = 63'd15000001;    add_vec(h, 2'd1, 0, ERR_OK, 0, 0);
        h = b; h.p_num = 63'd12964999; h.c_num = 63'd12965000; h.c_lim = 64'd30029000;
        add_vec(h, 2'd0, 0, ERR_OK, 0, 0);
        h = '1; h.pad = '0;                     add_vec(h, 2'd3, 0, ERR_OK, 0, 0);
        h = '0;                                 add_vec(h, 2'd0, 0, ERR_OK, 0, 0);
        h = b; h.p_num = '1; h.c_num = '0;      add_vec(h, 2'd2, 0, ERR_OK, 0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (vecs[i])
            send_pair(vecs[i].hp, vecs[i].pres, vecs[i].typed, vecs[i].v,
                      $urandom_range(0, 15));
        random_phase(450);
        write_london(63'd0);
        random_phase(300);
        write_london('1);
        random_phase(250);
        write_london(63'($urandom_range(1, 1 << 20)));
        random_phase(300);
        write_london(LONDON_RESET);
        random_phase(200);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (140) @(posedge aclk);
        if (n_fail == 0 && !m_tvalid)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
